/* hdl/akf_pkg.sv */
`timescale 1ns / 1ps
package akf_pkg;

    // Default number of fraction bits of the state and register format.
    localparam int FRAC_BITS_DEF = 16;

    // The time step always carries 16 fraction bits.
    localparam int DT_FRAC = 16;
    localparam int DT_W = 17;
    localparam logic [DT_W-1:0] DT_ONE = 17'd65536;
    localparam logic [DT_W-1:0] DT_DEFAULT = 17'd1311;

    // Width of the accumulation path in the write-back step.
    localparam int ACC_W = 66;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_ALT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_VEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_MEAS = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_WB,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } akf_state_t;

    typedef enum logic [3:0] {
        OP_ALT_P,
        OP_FP00,
        OP_FP01,
        OP_P00,
        OP_P10,
        OP_ALT_NEW,
        OP_VEL_NEW,
        OP_COV_AA,
        OP_COV_AV,
        OP_COV_VA,
        OP_COV_VV
    } akf_op_t;

    // Handshake between the sequencer and the divider.
    typedef struct packed {
        logic start;
    } akf_div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } akf_div_status_t;

    // Saturate a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-32:0] hi;
        hi = v[ACC_W-1:31];
        if ((&hi) || !(|hi)) begin
            return v[31:0];
        end
        return v[ACC_W-1] ? 32'sh80000000 : 32'sh7fffffff;
    endfunction

endpackage

/* hdl/altitude_velocity_kalman_unit.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    baro_altitude, time_step
// output    out        out_valid / out_stall  altitude_estimate, velocity_estimate,
//                                             first_sample
// config    in         cfg_we                 cfg_index, cfg_data
//
// The first request after reset goes straight to the output step and only
// loads the state. Every later request runs eleven multiply steps, each a
// multiply state followed by a write-back state, on one shared multiplier and,
// when the innovation variance is positive, two divisions on the shared
// restoring divider. The next request can be taken once the result has moved
// into the output register.
// in_stall stays high from acceptance until the result has moved
// into the output register; a waiting result does not block the next request.
// Reset is asynchronous and active low; it loads identity covariance, zero
// state and the default noise registers.
module altitude_velocity_kalman_unit #(
    parameter int FRAC_BITS = akf_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [31:0]              baro_altitude,
    input  logic [akf_pkg::DT_W-1:0]        time_step,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [31:0]              altitude_estimate,
    output logic signed [31:0]              velocity_estimate,
    output logic                            first_sample,
    input  logic                            cfg_we,
    input  logic [akf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data
);
    import akf_pkg::*;

    localparam longint ONE_L = longint'(1) << FRAC_BITS;
    localparam logic [31:0] NOISE_ALT_RST = 32'((ONE_L + 50) / 100);
    localparam logic [31:0] NOISE_VEL_RST = 32'((ONE_L * 10 + 50) / 100);
    localparam logic [31:0] NOISE_MEAS_RST = 32'(ONE_L);
    localparam logic signed [31:0] ONE_FX = 32'(ONE_L);
    // Dividend width: magnitude shifted up by the fraction bits plus half
    // the divisor for rounding.
    localparam int NUM_W = 33 + FRAC_BITS;
    localparam int DEN_W = 33;

    // Configuration registers.
    logic [31:0] noise_alt_reg;
    logic [31:0] noise_vel_reg;
    logic [31:0] noise_meas_reg;

    // Filter state.
    logic signed [31:0] alt_reg, vel_reg;
    logic signed [31:0] aa_reg, av_reg, va_reg, vv_reg;
    logic               started_reg;

    // Per-request working registers.
    logic signed [31:0]      baro_reg;
    logic [DT_W-1:0]         dt_reg;
    logic                    first_reg;
    logic signed [31:0]      altp_reg, fp00_reg, fp01_reg;
    logic signed [31:0]      p00_reg, p10_reg, p11_reg;
    logic signed [31:0]      k0_reg, k1_reg, innov_reg, omk_reg;
    logic signed [33:0]      s_reg;
    logic signed [64:0]      prod_reg;
    logic                    div_sel_reg;
    logic                    div_neg_reg;

    // Sequencer.
    akf_state_t state_reg, state_next;
    akf_op_t    op_reg, op_next;

    // Output register.
    logic               out_valid_reg;
    logic signed [31:0] out_alt_reg, out_vel_reg;
    logic               out_first_reg;

    logic in_acc;
    logic out_load;
    logic s_pos;

    assign in_acc = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign s_pos = !s_reg[33] && (s_reg != '0);

    // Divider and its operands.
    akf_div_ctrl_t      div_ctrl;
    akf_div_status_t    div_status;
    logic [NUM_W-1:0]   div_num;
    logic [NUM_W-1:0]   div_quot;
    logic signed [31:0] div_src;
    logic [31:0]        div_mag;
    logic signed [31:0] k_sat;

    akf_divider #(
        .NUM_W(NUM_W),
        .DEN_W(DEN_W)
    ) u_div (
        .clk(clk),
        .rst_n(rst_n),
        .ctrl(div_ctrl),
        .numerator(div_num),
        .denominator(s_reg[DEN_W-1:0]),
        .status(div_status),
        .quotient(div_quot)
    );

    always_comb
    begin
        div_src = div_sel_reg ? p10_reg : p00_reg;
        div_mag = div_src[31] ? 32'(-div_src) : 32'(div_src);
        div_num = {1'b0, div_mag, {FRAC_BITS{1'b0}}}
                + {{(NUM_W-32){1'b0}}, s_reg[32:1]};
    end

    // Apply the sign to the quotient and saturate it.
    always_comb
    begin
        if (!div_neg_reg) begin
            if (|div_quot[NUM_W-1:31]) begin
                k_sat = 32'sh7fffffff;
            end else begin
                k_sat = div_quot[31:0];
            end
        end else begin
            if ((|div_quot[NUM_W-1:32]) || (div_quot[31] && (|div_quot[30:0]))) begin
                k_sat = 32'sh80000000;
            end else begin
                k_sat = 32'(-div_quot[31:0]);
            end
        end
    end

    // Operand selection of the shared multiply-accumulate step.
    logic signed [31:0]      mul_a;
    logic signed [32:0]      mul_b;
    logic                    use_dt;
    logic                    sub_prod;
    logic signed [ACC_W-1:0] acc_base;

    always_comb
    begin
        mul_a = vel_reg;
        mul_b = $signed({16'b0, dt_reg});
        use_dt = 1'b1;
        sub_prod = 1'b0;
        acc_base = ACC_W'(alt_reg);
        case (op_reg)
            OP_ALT_P: begin
                mul_a = vel_reg;
                acc_base = ACC_W'(alt_reg);
            end
            OP_FP00: begin
                mul_a = va_reg;
                acc_base = ACC_W'(aa_reg);
            end
            OP_FP01: begin
                mul_a = vv_reg;
                acc_base = ACC_W'(av_reg);
            end
            OP_P00: begin
                mul_a = fp01_reg;
                acc_base = ACC_W'(fp00_reg) + $signed({{(ACC_W-32){1'b0}}, noise_alt_reg});
            end
            OP_P10: begin
                mul_a = vv_reg;
                acc_base = ACC_W'(va_reg);
            end
            OP_ALT_NEW: begin
                mul_a = k0_reg;
                mul_b = 33'(innov_reg);
                use_dt = 1'b0;
                acc_base = ACC_W'(altp_reg);
            end
            OP_VEL_NEW: begin
                mul_a = k1_reg;
                mul_b = 33'(innov_reg);
                use_dt = 1'b0;
                acc_base = ACC_W'(vel_reg);
            end
            OP_COV_AA: begin
                mul_a = omk_reg;
                mul_b = 33'(p00_reg);
                use_dt = 1'b0;
                acc_base = '0;
            end
            OP_COV_AV: begin
                mul_a = omk_reg;
                mul_b = 33'(fp01_reg);
                use_dt = 1'b0;
                acc_base = '0;
            end
            OP_COV_VA: begin
                mul_a = k1_reg;
                mul_b = 33'(p00_reg);
                use_dt = 1'b0;
                sub_prod = 1'b1;
                acc_base = ACC_W'(p10_reg);
            end
            OP_COV_VV: begin
                mul_a = k1_reg;
                mul_b = 33'(fp01_reg);
                use_dt = 1'b0;
                sub_prod = 1'b1;
                acc_base = ACC_W'(p11_reg);
            end
            default: begin
                mul_a = vel_reg;
            end
        endcase
    end

    // Write-back: round the product to nearest with ties away from zero,
    // which for a negative product is (p + half - 1) shifted arithmetically.
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] rnd_dt, rnd_fx, rnd;
    logic signed [ACC_W-1:0] acc_sum;
    logic signed [31:0]      wb_val;

    always_comb
    begin
        prod_ext = ACC_W'(prod_reg);
        rnd_dt = (prod_ext + (ACC_W'(1) <<< (DT_FRAC - 1))
                 - $signed({{(ACC_W-1){1'b0}}, prod_reg[64]})) >>> DT_FRAC;
        rnd_fx = (prod_ext + (ACC_W'(1) <<< (FRAC_BITS - 1))
                 - $signed({{(ACC_W-1){1'b0}}, prod_reg[64]})) >>> FRAC_BITS;
        rnd = use_dt ? rnd_dt : rnd_fx;
        acc_sum = sub_prod ? (acc_base - rnd) : (acc_base + rnd);
        wb_val = sat32(acc_sum);
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    state_next = started_reg ? ST_MUL : ST_OUT;
                    op_next = OP_ALT_P;
                end
            end
            ST_MUL: begin
                state_next = ST_WB;
            end
            ST_WB: begin
                state_next = ST_MUL;
                case (op_reg)
                    OP_ALT_P:   op_next = OP_FP00;
                    OP_FP00:    op_next = OP_FP01;
                    OP_FP01:    op_next = OP_P00;
                    OP_P00:     op_next = OP_P10;
                    OP_P10:     state_next = ST_DIV_START;
                    OP_ALT_NEW: op_next = OP_VEL_NEW;
                    OP_VEL_NEW: op_next = OP_COV_AA;
                    OP_COV_AA:  op_next = OP_COV_AV;
                    OP_COV_AV:  op_next = OP_COV_VA;
                    OP_COV_VA:  op_next = OP_COV_VV;
                    default:    state_next = ST_OUT;
                endcase
            end
            ST_DIV_START: begin
                if (s_pos) begin
                    state_next = ST_DIV_WAIT;
                end else begin
                    state_next = ST_MUL;
                    op_next = OP_ALT_NEW;
                end
            end
            ST_DIV_WAIT: begin
                if (div_status.done) begin
                    if (div_sel_reg) begin
                        state_next = ST_MUL;
                        op_next = OP_ALT_NEW;
                    end else begin
                        state_next = ST_DIV_START;
                    end
                end
            end
            ST_OUT: begin
                if (!out_valid_reg || !out_stall) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        div_ctrl.start = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_DIV_START: div_ctrl.start = s_pos;
            ST_OUT:       out_load = !out_valid_reg || !out_stall;
            default:      out_load = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            op_reg <= OP_ALT_P;
            noise_alt_reg <= NOISE_ALT_RST;
            noise_vel_reg <= NOISE_VEL_RST;
            noise_meas_reg <= NOISE_MEAS_RST;
            alt_reg <= '0;
            vel_reg <= '0;
            aa_reg <= ONE_FX;
            av_reg <= '0;
            va_reg <= '0;
            vv_reg <= ONE_FX;
            started_reg <= 1'b0;
            div_sel_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            op_reg <= op_next;

            if (cfg_we) begin
                case (cfg_index)
                    CFG_NOISE_ALT:  noise_alt_reg <= cfg_data;
                    CFG_NOISE_VEL:  noise_vel_reg <= cfg_data;
                    CFG_NOISE_MEAS: noise_meas_reg <= cfg_data;
                    default:        noise_alt_reg <= noise_alt_reg;
                endcase
            end

            if (in_acc) begin
                started_reg <= 1'b1;
                div_sel_reg <= 1'b0;
                if (!started_reg) begin
                    alt_reg <= baro_altitude;
                    vel_reg <= '0;
                end
            end

            if (state_reg == ST_WB) begin
                case (op_reg)
                    OP_ALT_NEW: alt_reg <= wb_val;
                    OP_VEL_NEW: vel_reg <= wb_val;
                    OP_COV_AA:  aa_reg <= wb_val;
                    OP_COV_AV:  av_reg <= wb_val;
                    OP_COV_VA:  va_reg <= wb_val;
                    OP_COV_VV:  vv_reg <= wb_val;
                    default:    alt_reg <= alt_reg;
                endcase
            end

            if ((state_reg == ST_DIV_WAIT) && div_status.done) begin
                div_sel_reg <= 1'b1;
            end

            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_acc) begin
            baro_reg <= baro_altitude;
            if ((time_step == '0) || (time_step > DT_ONE)) begin
                dt_reg <= DT_DEFAULT;
            end else begin
                dt_reg <= time_step;
            end
            first_reg <= !started_reg;
        end

        if (state_reg == ST_MUL) begin
            prod_reg <= mul_a * mul_b;
        end

        if (state_reg == ST_WB) begin
            case (op_reg)
                OP_ALT_P: altp_reg <= wb_val;
                OP_FP00:  fp00_reg <= wb_val;
                OP_FP01:  fp01_reg <= wb_val;
                OP_P00:   p00_reg <= wb_val;
                OP_P10:
                begin
                    p10_reg <= wb_val;
                    p11_reg <= sat32(ACC_W'(vv_reg)
                                     + $signed({{(ACC_W-32){1'b0}}, noise_vel_reg}));
                    s_reg <= {{2{p00_reg[31]}}, p00_reg} + {2'b00, noise_meas_reg};
                    innov_reg <= sat32(ACC_W'(baro_reg) - ACC_W'(altp_reg));
                end
                default:  prod_reg <= prod_reg;
            endcase
        end

        // With a non-positive innovation variance both gains are zero.
        if ((state_reg == ST_DIV_START) && !s_pos) begin
            k0_reg <= '0;
            k1_reg <= '0;
            omk_reg <= ONE_FX;
        end

        if (div_ctrl.start) begin
            div_neg_reg <= div_src[31];
        end

        if ((state_reg == ST_DIV_WAIT) && div_status.done) begin
            if (div_sel_reg) begin
                k1_reg <= k_sat;
            end else begin
                k0_reg <= k_sat;
                omk_reg <= sat32(ACC_W'(ONE_FX) - ACC_W'(k_sat));
            end
        end

        if (out_load) begin
            out_alt_reg <= alt_reg;
            out_vel_reg <= vel_reg;
            out_first_reg <= first_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign altitude_estimate = out_alt_reg;
    assign velocity_estimate = out_vel_reg;
    assign first_sample = out_first_reg;

    // The first request after reset only loads the state and goes straight to the output.
    a_first_direct: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && !started_reg |=> state_reg == ST_OUT)
        else $error("first sample did not go straight to the output");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> state_reg == ST_DIV_WAIT)
        else $error("divider finished outside the wait state");

    // The divider is never restarted while it is still working.
    a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctrl.start |-> !div_status.busy)
        else $error("divider started while busy");

    // A waiting result is never overwritten before it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !out_load)
        else $error("pending result overwritten");

endmodule

/* hdl/akf_divider.sv */
`timescale 1ns / 1ps
module akf_divider #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 33
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  akf_pkg::akf_div_ctrl_t    ctrl,
    input  logic [NUM_W-1:0]          numerator,
    input  logic [DEN_W-1:0]          denominator,
    output akf_pkg::akf_div_status_t  status,
    output logic [NUM_W-1:0]          quotient
);
    import akf_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    // Restoring division, one quotient bit per cycle. The dividend shifts
    // out at the top while quotient bits shift in at the bottom.
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;

    always_comb
    begin
        shifted = {rem_reg, num_reg[NUM_W-1]};
        diff = shifted - {1'b0, den_reg};
        num_next = num_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start) begin
            num_next = numerator;
            rem_next = '0;
            cnt_next = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[DEN_W]) begin
                rem_next = diff[DEN_W-1:0];
            end else begin
                rem_next = shifted[DEN_W-1:0];
            end
            num_next = {num_reg[NUM_W-2:0], !diff[DEN_W]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        if (ctrl.start) begin
            den_reg <= denominator;
        end
    end

    assign quotient = num_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
